>>> rtl/jst_pkg.sv
// Shared constants, types and helper functions of the JSON stream tokenizer.
package jst_pkg;

	localparam logic [3:0] PH_START       = 4'd0;
	localparam logic [3:0] PH_ARRAY       = 4'd1;
	localparam logic [3:0] PH_OBJECT      = 4'd2;
	localparam logic [3:0] PH_END_KEY     = 4'd3;
	localparam logic [3:0] PH_AFTER_KEY   = 4'd4;
	localparam logic [3:0] PH_STRING      = 4'd5;
	localparam logic [3:0] PH_ESCAPE      = 4'd6;
	localparam logic [3:0] PH_UNICODE     = 4'd7;
	localparam logic [3:0] PH_AFTER_VALUE = 4'd8;
	localparam logic [3:0] PH_NUMBER      = 4'd9;
	localparam logic [3:0] PH_TRUE        = 4'd10;
	localparam logic [3:0] PH_FALSE       = 4'd11;
	localparam logic [3:0] PH_NULL        = 4'd12;

	localparam logic [1:0] NS_OBJECT = 2'd0;
	localparam logic [1:0] NS_ARRAY  = 2'd1;
	localparam logic [1:0] NS_KEY    = 2'd2;
	localparam logic [1:0] NS_STRING = 2'd3;

	localparam logic [3:0] EV_DOC_START = 4'd0;
	localparam logic [3:0] EV_OBJ_START = 4'd1;
	localparam logic [3:0] EV_OBJ_END   = 4'd2;
	localparam logic [3:0] EV_ARR_START = 4'd3;
	localparam logic [3:0] EV_ARR_END   = 4'd4;
	localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
	localparam logic [3:0] EV_STR_BYTE  = 4'd6;
	localparam logic [3:0] EV_NUM_BYTE  = 4'd7;
	localparam logic [3:0] EV_TRUE      = 4'd8;
	localparam logic [3:0] EV_FALSE     = 4'd9;
	localparam logic [3:0] EV_NULL      = 4'd10;
	localparam logic [3:0] EV_DOC_END   = 4'd11;
	localparam logic [3:0] EV_OVERFLOW  = 4'd12;
	localparam logic [3:0] EV_KEY_END   = 4'd13;
	localparam logic [3:0] EV_STR_END   = 4'd14;

	localparam logic [7:0]  LEAD2       = 8'hC0;
	localparam logic [7:0]  CONT        = 8'h80;
	localparam logic [15:0] RIGHT_QUOTE = 16'h2019;
	localparam logic [7:0]  CTRL_LIMIT  = 8'h1F;
	localparam logic [7:0]  DEL_BYTE    = 8'h7F;

	typedef struct packed {
		logic       en;
		logic [3:0] kind;
	} ev_req_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
	endfunction

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= "0" && c <= "9") d = c - 8'h30;
		else if (c >= "a" && c <= "f") d = c - 8'h57;
		else if (c >= "A" && c <= "F") d = c - 8'h37;
		return d[3:0];
	endfunction

	function automatic logic [7:0] lit_char(input logic [3:0] ph, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (ph)
			PH_TRUE: begin
				case (idx)
					3'd0: r = "t";
					3'd1: r = "r";
					3'd2: r = "u";
					3'd3: r = "e";
					default: r = 8'h00;
				endcase
			end
			PH_FALSE: begin
				case (idx)
					3'd0: r = "f";
					3'd1: r = "a";
					3'd2: r = "l";
					3'd3: r = "s";
					3'd4: r = "e";
					default: r = 8'h00;
				endcase
			end
			PH_NULL: begin
				case (idx)
					3'd0: r = "n";
					3'd1: r = "u";
					3'd2: r = "l";
					3'd3: r = "l";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/jst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module jst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/json_stream_tokenizer.sv
// Top level of the JSON stream tokenizer: parse control, stack and text memories.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_byte
// out     | out | out_valid/out_stall| event_kind data_byte number_is_float nest_depth last_of_run
//
// A byte is accepted in S_IDLE, then parsed in S_HANDLE; a further result is sent from S_EV2,
// and a buffered text run is read out byte by byte from S_DOUT through the single read port
// of the text memory. A split UTF-8 escape writes its second text byte in S_PUT2.
// Reset is asynchronous; memories are not cleared, only control state.
// out_stall holds the sequencer wherever a result waits; in_stall is high while busy.
module json_stream_tokenizer import jst_pkg::*; #(
	parameter int TEXT_DEPTH  = 32,
	parameter int STACK_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         in_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         event_kind,
	output logic [7:0]                         data_byte,
	output logic                               number_is_float,
	output logic [$clog2(STACK_DEPTH+1)-1:0]   nest_depth,
	output logic                               last_of_run
);

	localparam int TW  = $clog2(TEXT_DEPTH);
	localparam int PW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HANDLE = 3'd1;
	localparam logic [2:0] S_DOUT   = 3'd2;
	localparam logic [2:0] S_EV2    = 3'd3;
	localparam logic [2:0] S_PUT2   = 3'd4;

	logic [2:0]    st_q, st_n;
	logic [7:0]    c_q;
	logic          again_q;
	logic [3:0]    ph_q;
	logic [PW-1:0] ptr_q;
	logic [1:0]    top_q;
	logic          top_ld_q;
	logic [TW-1:0] tl_q;
	logic [2:0]    hc_q;
	logic [15:0]   hv_q;
	logic          seen_q;
	logic          lit_q;
	logic [7:0]    put2_q;
	logic [TW-1:0] dlen_q, di_q;
	logic [3:0]    dbk_q;
	logic          dflt_q, dend_q, drep_q, dtail_q;
	logic [3:0]    ev2_kind_q;
	logic [PW-1:0] ev2_depth_q;

	logic          ov_q, last_q, flt_q;
	logic [3:0]    kind_q;
	logic [7:0]    data_q;
	logic [PW-1:0] depth_q;

	logic [1:0]    s_rdata;
	logic [7:0]    t_rdata;

	logic          ofree;
	logic          ws_skip;

	logic [3:0]    ph_n;
	logic [PW-1:0] ptr_n;
	logic [TW-1:0] tl_n;
	logic [2:0]    hc_n;
	logic [15:0]   hv_n;
	logic          seen_n, lit_n;
	logic          put_en, put2_en, push_en, pop_rd;
	logic [7:0]    put_byte, put2_byte;
	logic [1:0]    push_kind;
	ev_req_t       e1, e2;
	logic [PW-1:0] e1_depth, e2_depth;
	logic          dump_en, dump_end, dump_rep, dump_tail;
	logic [3:0]    dump_bk, dump_endk;
	logic          do_close, do_open, do_pstr, do_sv;
	logic [3:0]    close_ev, open_ev, open_ph;
	logic [1:0]    open_kind, pstr_kind;
	logic          push_ok;
	logic [PW-1:0] newp;
	logic [15:0]   cp;
	logic [TW-1:0] tl_inc;

	logic          em_en, em_last, em_flt;
	logic [3:0]    em_kind;
	logic [7:0]    em_data;
	logic [PW-1:0] em_depth;
	logic          t_we, t_re;
	logic [TW-1:0] t_waddr, t_raddr;
	logic [7:0]    t_wdata;

	assign ofree   = !ov_q || !out_stall;
	assign push_ok = ptr_q < PW'(STACK_DEPTH);
	assign newp    = (ptr_q == '0) ? '0 : ptr_q - PW'(1);
	assign tl_inc  = (tl_q < TW'(TEXT_DEPTH - 1)) ? tl_q + TW'(1) : tl_q;
	assign ws_skip = is_ws(c_q) && (ph_q inside {PH_ARRAY, PH_OBJECT, PH_END_KEY,
		PH_AFTER_KEY, PH_AFTER_VALUE, PH_TRUE, PH_FALSE, PH_NULL});

	always_comb begin
		ph_n = ph_q;
		ptr_n = ptr_q;
		tl_n = tl_q;
		hc_n = hc_q;
		hv_n = hv_q;
		seen_n = seen_q;
		lit_n = lit_q;
		put_en = 1'b0;
		put_byte = c_q;
		put2_en = 1'b0;
		put2_byte = 8'h00;
		push_en = 1'b0;
		push_kind = NS_OBJECT;
		pop_rd = 1'b0;
		e1 = '0;
		e2 = '0;
		e1_depth = ptr_q;
		e2_depth = ptr_q;
		dump_en = 1'b0;
		dump_end = 1'b0;
		dump_rep = 1'b0;
		dump_tail = 1'b0;
		dump_bk = EV_NUM_BYTE;
		dump_endk = EV_STR_END;
		do_close = 1'b0;
		do_open = 1'b0;
		do_pstr = 1'b0;
		do_sv = 1'b0;
		close_ev = EV_OBJ_END;
		open_ev = EV_OBJ_START;
		open_ph = PH_OBJECT;
		open_kind = NS_OBJECT;
		pstr_kind = NS_STRING;
		cp = {hv_q[11:0], hex_digit(c_q)};

		if (!ws_skip) begin
			case (ph_q)
				PH_STRING: begin
					if (c_q == "\"") begin
						tl_n = '0;
						if (ptr_q != '0) begin
							ptr_n = newp;
							pop_rd = (newp != '0);
							if (top_q == NS_KEY || top_q == NS_STRING) begin
								dump_en = 1'b1;
								dump_end = 1'b1;
								dump_bk = (top_q == NS_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
								dump_endk = (top_q == NS_KEY) ? EV_KEY_END : EV_STR_END;
								ph_n = (top_q == NS_KEY) ? PH_END_KEY : PH_AFTER_VALUE;
							end
						end
					end else if (c_q == "\\") begin
						ph_n = PH_ESCAPE;
					end else if (c_q < CTRL_LIMIT || c_q == DEL_BYTE) begin
						ph_n = ph_q;
					end else begin
						put_en = 1'b1;
					end
				end
				PH_ARRAY: begin
					if (c_q == "]") begin
						do_close = 1'b1;
						close_ev = EV_ARR_END;
					end else begin
						do_sv = 1'b1;
					end
				end
				PH_OBJECT: begin
					if (c_q == "}") begin
						do_close = 1'b1;
						close_ev = EV_OBJ_END;
					end else if (c_q == "\"") begin
						do_pstr = 1'b1;
						pstr_kind = NS_KEY;
					end
				end
				PH_END_KEY: ph_n = PH_AFTER_KEY;
				PH_AFTER_KEY: do_sv = 1'b1;
				PH_ESCAPE: begin
					ph_n = PH_STRING;
					put_en = 1'b1;
					case (c_q)
						"\"", "\\", "/": put_byte = c_q;
						"b": put_byte = 8'h08;
						"f": put_byte = 8'h0C;
						"n": put_byte = 8'h0A;
						"r": put_byte = 8'h0D;
						"t": put_byte = 8'h09;
						"u": begin
							put_en = 1'b0;
							ph_n = PH_UNICODE;
							hc_n = '0;
							hv_n = '0;
						end
						default: put_en = 1'b0;
					endcase
				end
				PH_UNICODE: begin
					hv_n = cp;
					hc_n = hc_q + 3'd1;
					if (hc_n >= 3'd4) begin
						put_en = 1'b1;
						if (cp < 16'h0080) begin
							put_byte = cp[7:0];
						end else if (cp < 16'h0800) begin
							put_byte = {3'b000, cp[10:6]} | LEAD2;
							put2_en = 1'b1;
							put2_byte = {2'b00, cp[5:0]} | CONT;
						end else if (cp == RIGHT_QUOTE) begin
							put_byte = "'";
						end else begin
							put_byte = " ";
						end
						hc_n = '0;
						hv_n = '0;
						ph_n = PH_STRING;
					end
				end
				PH_AFTER_VALUE: begin
					if (ptr_q != '0 && top_q == NS_OBJECT) begin
						if (c_q == "}") begin
							do_close = 1'b1;
							close_ev = EV_OBJ_END;
						end else if (c_q == ",") begin
							ph_n = PH_OBJECT;
						end
					end else if (ptr_q != '0 && top_q == NS_ARRAY) begin
						if (c_q == "]") begin
							do_close = 1'b1;
							close_ev = EV_ARR_END;
						end else if (c_q == ",") begin
							ph_n = PH_ARRAY;
						end
					end
				end
				PH_NUMBER: begin
					if ((c_q >= "0" && c_q <= "9") || c_q == "e" || c_q == "E" ||
						c_q == "+" || c_q == "-") begin
						put_en = 1'b1;
					end else if (c_q == ".") begin
						seen_n = 1'b1;
						put_en = 1'b1;
					end else begin
						dump_en = 1'b1;
						dump_bk = EV_NUM_BYTE;
						dump_rep = again_q;
						dump_tail = again_q && ptr_q != '0 &&
							((top_q == NS_OBJECT && c_q == "}") ||
							(top_q == NS_ARRAY && c_q == "]"));
						tl_n = '0;
						seen_n = 1'b0;
						ph_n = PH_AFTER_VALUE;
					end
				end
				PH_TRUE, PH_FALSE, PH_NULL: begin
					put_en = 1'b1;
					lit_n = lit_q && (c_q == lit_char(ph_q, tl_q[2:0]));
					tl_n = tl_inc;
					if ((ph_q == PH_FALSE && tl_inc == TW'(5)) ||
						(ph_q != PH_FALSE && tl_inc == TW'(4))) begin
						e1.en = lit_n;
						e1.kind = (ph_q == PH_TRUE) ? EV_TRUE :
							(ph_q == PH_FALSE) ? EV_FALSE : EV_NULL;
						tl_n = '0;
						ph_n = PH_AFTER_VALUE;
					end
				end
				default: begin
					ph_n = PH_START;
					e1.en = 1'b1;
					e1.kind = EV_DOC_START;
					if (c_q == "[") begin
						do_open = 1'b1;
						open_kind = NS_ARRAY;
						open_ev = EV_ARR_START;
						open_ph = PH_ARRAY;
					end else if (c_q == "{") begin
						do_open = 1'b1;
					end
				end
			endcase
		end

		if (do_sv) begin
			if (c_q == "[") begin
				do_open = 1'b1;
				open_kind = NS_ARRAY;
				open_ev = EV_ARR_START;
				open_ph = PH_ARRAY;
			end else if (c_q == "{") begin
				do_open = 1'b1;
			end else if (c_q == "\"") begin
				do_pstr = 1'b1;
			end else if ((c_q >= "0" && c_q <= "9") || c_q == "-") begin
				ph_n = PH_NUMBER;
				seen_n = 1'b0;
				put_en = 1'b1;
			end else if (c_q == "t" || c_q == "f" || c_q == "n") begin
				ph_n = (c_q == "t") ? PH_TRUE : (c_q == "f") ? PH_FALSE : PH_NULL;
				put_en = 1'b1;
				lit_n = 1'b1;
			end
		end

		if (put_en && !(ph_q == PH_TRUE || ph_q == PH_FALSE || ph_q == PH_NULL)) begin
			tl_n = tl_inc;
		end

		if (do_close) begin
			ptr_n = newp;
			pop_rd = (newp != '0);
			e1.en = 1'b1;
			e1.kind = close_ev;
			e1_depth = newp;
			ph_n = PH_AFTER_VALUE;
			if (newp == '0) begin
				e2.en = 1'b1;
				e2.kind = EV_DOC_END;
				e2_depth = '0;
				ph_n = PH_START;
				tl_n = '0;
				hc_n = '0;
				hv_n = '0;
			end
		end

		if (do_open || do_pstr) begin
			if (push_ok) begin
				push_en = 1'b1;
				push_kind = do_open ? open_kind : pstr_kind;
				ptr_n = ptr_q + PW'(1);
				ph_n = do_open ? open_ph : PH_STRING;
			end
			if (do_open || !push_ok) begin
				if (e1.en) begin
					e2.en = 1'b1;
					e2.kind = push_ok ? open_ev : EV_OVERFLOW;
					e2_depth = push_ok ? ptr_q + PW'(1) : ptr_q;
				end else begin
					e1.en = 1'b1;
					e1.kind = push_ok ? open_ev : EV_OVERFLOW;
					e1_depth = push_ok ? ptr_q + PW'(1) : ptr_q;
				end
			end
		end
	end

	always_comb begin
		st_n = st_q;
		em_en = 1'b0;
		em_kind = EV_DOC_START;
		em_data = 8'h00;
		em_flt = 1'b0;
		em_depth = ptr_q;
		em_last = 1'b1;
		t_we = 1'b0;
		t_waddr = tl_q;
		t_wdata = put_byte;
		t_re = 1'b0;
		t_raddr = '0;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) st_n = S_HANDLE;
			end
			S_HANDLE: begin
				if (ofree) begin
					t_we = put_en;
					if (e1.en) begin
						em_en = 1'b1;
						em_kind = e1.kind;
						em_depth = e1_depth;
						em_last = !e2.en;
					end
					if (e2.en) begin
						st_n = S_EV2;
					end else if (dump_en && tl_q == '0) begin
						st_n = S_EV2;
					end else if (dump_en) begin
						t_re = 1'b1;
						st_n = S_DOUT;
					end else if (put2_en) begin
						st_n = S_PUT2;
					end else begin
						st_n = S_IDLE;
					end
				end
			end
			S_DOUT: begin
				if (ofree) begin
					em_en = 1'b1;
					em_kind = dbk_q;
					em_data = t_rdata;
					if (di_q + TW'(1) == dlen_q) begin
						em_flt = dflt_q;
						em_last = !dend_q && !(drep_q && dtail_q);
						st_n = dend_q ? S_EV2 : drep_q ? S_HANDLE : S_IDLE;
					end else begin
						em_last = 1'b0;
						t_re = 1'b1;
						t_raddr = di_q + TW'(1);
					end
				end
			end
			S_EV2: begin
				if (ofree) begin
					em_en = 1'b1;
					em_kind = ev2_kind_q;
					em_depth = ev2_depth_q;
					st_n = S_IDLE;
				end
			end
			S_PUT2: begin
				t_we = 1'b1;
				t_wdata = put2_q;
				st_n = S_IDLE;
			end
			default: st_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= PH_START;
			ptr_q <= '0;
			tl_q <= '0;
			hc_q <= '0;
			hv_q <= '0;
			seen_q <= 1'b0;
			lit_q <= 1'b0;
			top_ld_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			top_ld_q <= 1'b0;
			if (st_q == S_HANDLE && ofree) begin
				ph_q <= ph_n;
				ptr_q <= ptr_n;
				tl_q <= tl_n;
				hc_q <= hc_n;
				hv_q <= hv_n;
				seen_q <= seen_n;
				lit_q <= lit_n;
				top_ld_q <= pop_rd;
			end
			if (st_q == S_PUT2) begin
				tl_q <= tl_inc;
			end
			if (em_en) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			c_q <= in_byte;
			again_q <= 1'b1;
		end
		if (top_ld_q) begin
			top_q <= s_rdata;
		end
		if (st_q == S_HANDLE && ofree) begin
			if (push_en) top_q <= push_kind;
			put2_q <= put2_byte;
			ev2_kind_q <= e2.en ? e2.kind : dump_endk;
			ev2_depth_q <= e2.en ? e2_depth : ptr_n;
			dlen_q <= tl_q;
			di_q <= '0;
			dbk_q <= dump_bk;
			dflt_q <= seen_q;
			dend_q <= dump_end;
			drep_q <= dump_rep;
			dtail_q <= dump_tail;
		end
		if (st_q == S_DOUT && ofree) begin
			di_q <= di_q + TW'(1);
			again_q <= 1'b0;
		end
		if (em_en) begin
			kind_q <= em_kind;
			data_q <= em_data;
			flt_q <= em_flt;
			depth_q <= em_depth;
			last_q <= em_last;
		end
	end

	jst_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (st_q == S_HANDLE && ofree && push_en),
		.waddr (ptr_q[SAW-1:0]),
		.wdata (push_kind),
		.re    (st_q == S_HANDLE && ofree && pop_rd),
		.raddr (SAW'(ptr_n - PW'(1))),
		.rdata (s_rdata)
	);

	jst_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	assign in_stall        = (st_q != S_IDLE);
	assign out_valid       = ov_q;
	assign event_kind      = kind_q;
	assign data_byte       = data_q;
	assign number_is_float = flt_q;
	assign nest_depth      = depth_q;
	assign last_of_run     = last_q;

endmodule

>>> rtl/jst_checker.sv
// Port-level checker of the JSON stream tokenizer and its bind.
module jst_checker import jst_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [7:0]                       in_byte,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [3:0]                       event_kind,
	input logic [7:0]                       data_byte,
	input logic                             number_is_float,
	input logic [$clog2(STACK_DEPTH+1)-1:0] nest_depth,
	input logic                             last_of_run
);

	localparam int PW = $clog2(STACK_DEPTH + 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
		$stable(data_byte) && $stable(nest_depth) && $stable(last_of_run))
		else $error("stalled transaction changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous byte in work");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nest_depth <= PW'(STACK_DEPTH))
		else $error("depth beyond stack size");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_KEY_BYTE && event_kind != EV_STR_BYTE &&
		event_kind != EV_NUM_BYTE |-> data_byte == 8'h00 && !number_is_float)
		else $error("data on non-text transaction");

	a_float: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && number_is_float |-> event_kind == EV_NUM_BYTE)
		else $error("float flag off a number byte");

endmodule

bind json_stream_tokenizer jst_checker #(.STACK_DEPTH(STACK_DEPTH)) u_jst_checker (.*);
